// ===== sv/cbe_pkg.sv =====
// ----------------------------------------------------------------------------
// cbe_pkg
// Shared widths, constants, types and helpers of the cubic bezier easing block.
// ----------------------------------------------------------------------------
package cbe_pkg;

  // fixed point format
  localparam int FRAC_BITS = 16;
  localparam int T_W       = FRAC_BITS + 1;       // progress and curve parameter
  localparam int Y_W       = 19;                  // signed control y and result
  localparam int COEF_W    = 20;                  // signed polynomial coefficients
  localparam int X_W       = 22;                  // signed x(u) - t
  localparam int D_W       = 23;                  // signed derivative
  localparam int MAG_W     = X_W - 1;             // magnitude of x(u) - t
  localparam int DM_W      = D_W - 1;             // magnitude of derivative
  localparam int QB        = T_W;                 // quotient bits kept
  localparam int REM_W     = DM_W + 1;            // divider partial remainder
  localparam int NF_W      = MAG_W + FRAC_BITS;   // scaled dividend
  localparam int TOP_W     = NF_W - QB;           // dividend bits above quotient
  localparam int UX_W      = QB + 3;              // signed updated parameter
  localparam int P_W       = 20;                  // signed y products
  localparam int ACC_W     = 24;                  // signed y sum

  localparam logic [T_W-1:0] ONE_Q = T_W'(1) << FRAC_BITS;
  localparam logic signed [ACC_W-1:0] Y_MAX = ACC_W'((1 << (Y_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] Y_MIN = -ACC_W'(1 << (Y_W - 1));

  // register indexes on the configuration port
  localparam logic [1:0] REG_X1 = 2'd0;
  localparam logic [1:0] REG_Y1 = 2'd1;
  localparam logic [1:0] REG_X2 = 2'd2;
  localparam logic [1:0] REG_Y2 = 2'd3;

  // reset values of the control points
  localparam logic [T_W-1:0] X1_RST = T_W'(28836);
  localparam logic [Y_W-1:0] Y1_RST = Y_W'(57672);
  localparam logic [T_W-1:0] X2_RST = T_W'(37356);
  localparam logic [Y_W-1:0] Y2_RST = Y_W'(82575);

  // polynomial coefficients of x(u)
  typedef struct packed {
    logic signed [COEF_W-1:0] f0;
    logic signed [COEF_W-1:0] f1;
    logic signed [COEF_W-1:0] f2;
  } coef_t;

  // item context carried alongside the divider
  typedef struct packed {
    logic [T_W-1:0] t;
    logic [T_W-1:0] u;
    logic           neg;
    logic           skip;
  } side_t;

  // clip a Q16 value to one
  function automatic logic [T_W-1:0] sat_one(input logic [T_W-1:0] v);
    return (v > ONE_Q) ? ONE_Q : v;
  endfunction

endpackage

// ===== sv/cbe_div.sv =====
// ----------------------------------------------------------------------------
// cbe_div
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// ----------------------------------------------------------------------------
module cbe_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  cbe_pkg::side_t                in_side,
  input  logic [cbe_pkg::REM_W-1:0]     in_rem,
  input  logic [cbe_pkg::DM_W-1:0]      in_dm,
  input  logic [cbe_pkg::QB-1:0]        in_low,
  input  logic                          in_ovf,
  output logic                          out_valid,
  output cbe_pkg::side_t                out_side,
  output logic [cbe_pkg::QB-1:0]        out_q,
  output logic                          out_ovf
);

  localparam int QB    = cbe_pkg::QB;
  localparam int REM_W = cbe_pkg::REM_W;
  localparam int DM_W  = cbe_pkg::DM_W;

  wire                   valid_s [QB+1];
  wire cbe_pkg::side_t   side_s  [QB+1];
  wire [REM_W-1:0]       rem_s   [QB+1];
  wire [DM_W-1:0]        dm_s    [QB+1];
  wire [QB-1:0]          low_s   [QB+1];
  wire [QB-1:0]          q_s     [QB+1];
  wire                   ovf_s   [QB+1];

  assign valid_s[0] = in_valid;
  assign side_s[0]  = in_side;
  assign rem_s[0]   = in_rem;
  assign dm_s[0]    = in_dm;
  assign low_s[0]   = in_low;
  assign q_s[0]     = '0;
  assign ovf_s[0]   = in_ovf;

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic                 valid_r;
    cbe_pkg::side_t       side_r;
    logic [REM_W-1:0]     rem_r;
    logic [DM_W-1:0]      dm_r;
    logic [QB-1:0]        low_r;
    logic [QB-1:0]        q_r;
    logic                 ovf_r;
    logic [REM_W-1:0]     shifted;
    logic                 ge;
    logic [REM_W-1:0]     rem_nxt;

    // shift in the next dividend bit and try the subtraction
    always_comb begin
      shifted = {rem_s[k][REM_W-2:0], low_s[k][QB-1]};
      ge      = shifted >= {1'b0, dm_s[k]};
      rem_nxt = ge ? (shifted - {1'b0, dm_s[k]}) : shifted;
    end

    // stage valid
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r <= 1'b0;
      end else if (en) begin
        valid_r <= valid_s[k];
      end
    end

    // stage payload
    always_ff @(posedge clk) begin
      if (en) begin
        side_r <= side_s[k];
        rem_r  <= rem_nxt;
        dm_r   <= dm_s[k];
        low_r  <= {low_s[k][QB-2:0], 1'b0};
        q_r    <= {q_s[k][QB-2:0], ge};
        ovf_r  <= ovf_s[k];
      end
    end

    assign valid_s[k+1] = valid_r;
    assign side_s[k+1]  = side_r;
    assign rem_s[k+1]   = rem_r;
    assign dm_s[k+1]    = dm_r;
    assign low_s[k+1]   = low_r;
    assign q_s[k+1]     = q_r;
    assign ovf_s[k+1]   = ovf_r;
  end

  assign out_valid = valid_s[QB];
  assign out_side  = side_s[QB];
  assign out_q     = q_s[QB];
  assign out_ovf   = ovf_s[QB];

endmodule

// ===== sv/cbe_newton.sv =====
// ----------------------------------------------------------------------------
// cbe_newton
// One pipelined Newton step of x(u) = t, with the update clamped to [0, one].
// ----------------------------------------------------------------------------
module cbe_newton (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  cbe_pkg::coef_t            coef,
  input  logic                      in_valid,
  input  logic [cbe_pkg::T_W-1:0]   in_t,
  input  logic [cbe_pkg::T_W-1:0]   in_u,
  output logic                      out_valid,
  output logic [cbe_pkg::T_W-1:0]   out_t,
  output logic [cbe_pkg::T_W-1:0]   out_u
);

  localparam int TW    = cbe_pkg::T_W;
  localparam int FB    = cbe_pkg::FRAC_BITS;
  localparam int CW    = cbe_pkg::COEF_W;
  localparam int XW    = cbe_pkg::X_W;
  localparam int DW    = cbe_pkg::D_W;
  localparam int MW    = cbe_pkg::MAG_W;
  localparam int DMW   = cbe_pkg::DM_W;
  localparam int QB    = cbe_pkg::QB;
  localparam int REM_W = cbe_pkg::REM_W;
  localparam int NF_W  = cbe_pkg::NF_W;
  localparam int UXW   = cbe_pkg::UX_W;
  localparam int PW    = CW + TW + 1;

  // stage a: u^2, f1*u, f2*u
  logic              a_valid_r;
  logic [TW-1:0]     a_t_r, a_u_r, a_u2_r;
  logic signed [CW-1:0] a_f1u_r, a_f2u_r;
  logic [2*TW-1:0]   a_uu_nxt;
  logic signed [PW-1:0] a_f1u_nxt, a_f2u_nxt;

  always_comb begin
    a_uu_nxt  = in_u * in_u;
    a_f1u_nxt = coef.f1 * $signed({1'b0, in_u});
    a_f2u_nxt = coef.f2 * $signed({1'b0, in_u});
  end

  // stage b: u^3, f0*u^2, f1*u^2
  logic              b_valid_r;
  logic [TW-1:0]     b_t_r, b_u_r, b_u3_r;
  logic signed [CW-1:0] b_f0u2_r, b_f1u2_r, b_f1u_r, b_f2u_r;
  logic [2*TW-1:0]   b_uuu_nxt;
  logic signed [PW-1:0] b_f0u2_nxt, b_f1u2_nxt;

  always_comb begin
    b_uuu_nxt  = a_u2_r * a_u_r;
    b_f0u2_nxt = coef.f0 * $signed({1'b0, a_u2_r});
    b_f1u2_nxt = coef.f1 * $signed({1'b0, a_u2_r});
  end

  // stage c: f0*u^3 and the derivative
  logic              c_valid_r;
  logic [TW-1:0]     c_t_r, c_u_r;
  logic signed [CW-1:0] c_f0u3_r, c_f1u2_r, c_f2u_r;
  logic signed [DW-1:0] c_d_r;
  logic signed [PW-1:0] c_f0u3_nxt;
  logic signed [DW-1:0] c_a, c_b, c_d_nxt;

  always_comb begin
    c_f0u3_nxt = coef.f0 * $signed({1'b0, b_u3_r});
    c_a        = DW'(b_f0u2_r);
    c_b        = DW'(b_f1u_r);
    c_d_nxt    = (c_a <<< 1) + c_a + (c_b <<< 1) + DW'(coef.f2);
  end

  // stage d: residual x(u) - t
  logic              d_valid_r;
  logic [TW-1:0]     d_t_r, d_u_r;
  logic signed [XW-1:0] d_num_r;
  logic signed [DW-1:0] d_d_r;
  logic signed [XW-1:0] d_num_nxt;

  always_comb begin
    d_num_nxt = XW'(c_f0u3_r) + XW'(c_f1u2_r) + XW'(c_f2u_r) - $signed(XW'(c_t_r));
  end

  // stage e: magnitudes, sign, range check and divider seed
  logic              e_valid_r;
  cbe_pkg::side_t    e_side_r;
  logic [REM_W-1:0]  e_rem_r;
  logic [DMW-1:0]    e_dm_r;
  logic [QB-1:0]     e_low_r;
  logic              e_ovf_r;
  logic [XW-1:0]     e_nmag_full;
  logic [DW-1:0]     e_dmag_full;
  logic [MW-1:0]     e_nmag;
  logic [DMW-1:0]    e_dmag;
  logic [NF_W-1:0]   e_nf;
  cbe_pkg::side_t    e_side_nxt;

  always_comb begin
    e_nmag_full     = d_num_r[XW-1] ? XW'(-d_num_r) : XW'(d_num_r);
    e_dmag_full     = d_d_r[DW-1] ? DW'(-d_d_r) : DW'(d_d_r);
    e_nmag          = e_nmag_full[MW-1:0];
    e_dmag          = e_dmag_full[DMW-1:0];
    e_nf            = {e_nmag, {FB{1'b0}}};
    e_side_nxt.t    = d_t_r;
    e_side_nxt.u    = d_u_r;
    e_side_nxt.neg  = d_num_r[XW-1] ^ d_d_r[DW-1];
    e_side_nxt.skip = (d_d_r == '0);
  end

  // pipeline registers, stages a to e
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
      e_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
      d_valid_r <= c_valid_r;
      e_valid_r <= d_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_t_r    <= in_t;
      a_u_r    <= in_u;
      a_u2_r   <= a_uu_nxt[FB +: TW];
      a_f1u_r  <= $signed(a_f1u_nxt[FB +: CW]);
      a_f2u_r  <= $signed(a_f2u_nxt[FB +: CW]);
      b_t_r    <= a_t_r;
      b_u_r    <= a_u_r;
      b_u3_r   <= b_uuu_nxt[FB +: TW];
      b_f0u2_r <= $signed(b_f0u2_nxt[FB +: CW]);
      b_f1u2_r <= $signed(b_f1u2_nxt[FB +: CW]);
      b_f1u_r  <= a_f1u_r;
      b_f2u_r  <= a_f2u_r;
      c_t_r    <= b_t_r;
      c_u_r    <= b_u_r;
      c_f0u3_r <= $signed(c_f0u3_nxt[FB +: CW]);
      c_f1u2_r <= b_f1u2_r;
      c_f2u_r  <= b_f2u_r;
      c_d_r    <= c_d_nxt;
      d_t_r    <= c_t_r;
      d_u_r    <= c_u_r;
      d_num_r  <= d_num_nxt;
      d_d_r    <= c_d_r;
      e_side_r <= e_side_nxt;
      e_rem_r  <= REM_W'(e_nf[NF_W-1:QB]);
      e_dm_r   <= e_dmag;
      e_low_r  <= e_nf[QB-1:0];
      e_ovf_r  <= {{(DMW - (NF_W - QB)){1'b0}}, e_nf[NF_W-1:QB]} >= e_dmag;
    end
  end

  // step quotient
  logic              q_valid;
  cbe_pkg::side_t    q_side;
  logic [QB-1:0]     q_val;
  logic              q_ovf;

  cbe_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (e_valid_r),
    .in_side   (e_side_r),
    .in_rem    (e_rem_r),
    .in_dm     (e_dm_r),
    .in_low    (e_low_r),
    .in_ovf    (e_ovf_r),
    .out_valid (q_valid),
    .out_side  (q_side),
    .out_q     (q_val),
    .out_ovf   (q_ovf)
  );

  // stage f: apply the step and clamp
  logic              f_valid_r;
  logic [TW-1:0]     f_t_r, f_u_r;
  logic [QB:0]       f_q;
  logic signed [UXW-1:0] f_ue, f_qe, f_s;
  logic [TW-1:0]     f_u_nxt;

  always_comb begin
    f_q  = q_ovf ? {1'b1, {QB{1'b0}}} : {1'b0, q_val};
    f_ue = $signed(UXW'(q_side.u));
    f_qe = $signed(UXW'(f_q));
    f_s  = q_side.neg ? (f_ue + f_qe) : (f_ue - f_qe);
    if (q_side.skip) begin
      f_u_nxt = q_side.u;
    end else if (f_s < 0) begin
      f_u_nxt = '0;
    end else if (f_s > $signed(UXW'(cbe_pkg::ONE_Q))) begin
      f_u_nxt = cbe_pkg::ONE_Q;
    end else begin
      f_u_nxt = f_s[TW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (en) begin
      f_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_t_r <= q_side.t;
      f_u_r <= f_u_nxt;
    end
  end

  assign out_valid = f_valid_r;
  assign out_t     = f_t_r;
  assign out_u     = f_u_r;

endmodule

// ===== sv/cbe_curve.sv =====
// ----------------------------------------------------------------------------
// cbe_curve
// Pipelined evaluation of y(u) with saturation to the 19-bit signed range.
// ----------------------------------------------------------------------------
module cbe_curve (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic signed [cbe_pkg::Y_W-1:0]   y1,
  input  logic signed [cbe_pkg::Y_W-1:0]   y2,
  input  logic                             in_valid,
  input  logic [cbe_pkg::T_W-1:0]          in_u,
  output logic                             out_valid,
  output logic [cbe_pkg::Y_W-1:0]          out_y,
  output logic                             out_sat
);

  localparam int TW  = cbe_pkg::T_W;
  localparam int FB  = cbe_pkg::FRAC_BITS;
  localparam int YW  = cbe_pkg::Y_W;
  localparam int PW  = cbe_pkg::P_W;
  localparam int AW  = cbe_pkg::ACC_W;
  localparam int MPW = TW + YW + 1;

  // stage 1: u^2, v = 1 - u, v^2
  logic [TW-1:0]   s1_v;
  logic [2*TW-1:0] s1_uu, s1_vv;
  logic            s1_valid_r;
  logic [TW-1:0]   s1_u_r, s1_v_r, s1_u2_r, s1_vv_r;

  always_comb begin
    s1_v  = cbe_pkg::ONE_Q - in_u;
    s1_uu = in_u * in_u;
    s1_vv = s1_v * s1_v;
  end

  // stage 2: u^3, v^2*u, v*u^2
  logic [2*TW-1:0] s2_uuu, s2_vvu, s2_vuu;
  logic            s2_valid_r;
  logic [TW-1:0]   s2_u3_r, s2_vvu_r, s2_vuu_r;

  always_comb begin
    s2_uuu = s1_u2_r * s1_u_r;
    s2_vvu = s1_vv_r * s1_u_r;
    s2_vuu = s1_v_r * s1_u2_r;
  end

  // stage 3: products with the control y values
  logic signed [MPW-1:0] s3_a, s3_b;
  logic            s3_valid_r;
  logic [TW-1:0]   s3_u3_r;
  logic signed [PW-1:0] s3_a_r, s3_b_r;

  always_comb begin
    s3_a = $signed({1'b0, s2_vvu_r}) * y1;
    s3_b = $signed({1'b0, s2_vuu_r}) * y2;
  end

  // stage 4: weighted sum and saturation
  logic signed [AW-1:0] s4_a, s4_b, s4_acc;
  logic signed [AW-1:0] s4_y;
  logic            s4_sat;
  logic            s4_valid_r;
  logic [YW-1:0]   s4_y_r;
  logic            s4_sat_r;

  always_comb begin
    s4_a   = AW'(s3_a_r);
    s4_b   = AW'(s3_b_r);
    s4_acc = (s4_a <<< 1) + s4_a + (s4_b <<< 1) + s4_b + $signed(AW'(s3_u3_r));
    s4_y   = s4_acc;
    s4_sat = 1'b0;
    if (s4_acc > cbe_pkg::Y_MAX) begin
      s4_y   = cbe_pkg::Y_MAX;
      s4_sat = 1'b1;
    end else if (s4_acc < cbe_pkg::Y_MIN) begin
      s4_y   = cbe_pkg::Y_MIN;
      s4_sat = 1'b1;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      s1_u_r   <= in_u;
      s1_v_r   <= s1_v;
      s1_u2_r  <= s1_uu[FB +: TW];
      s1_vv_r  <= s1_vv[FB +: TW];
      s2_u3_r  <= s2_uuu[FB +: TW];
      s2_vvu_r <= s2_vvu[FB +: TW];
      s2_vuu_r <= s2_vuu[FB +: TW];
      s3_u3_r  <= s2_u3_r;
      s3_a_r   <= $signed(s3_a[FB +: PW]);
      s3_b_r   <= $signed(s3_b[FB +: PW]);
      s4_y_r   <= s4_y[YW-1:0];
      s4_sat_r <= s4_sat;
    end
  end

  assign out_valid = s4_valid_r;
  assign out_y     = s4_y_r;
  assign out_sat   = s4_sat_r;

endmodule

// ===== sv/cubic_bezier_easing_top.sv =====
// ----------------------------------------------------------------------------
// cubic_bezier_easing_top
// Cubic bezier timing curve: progress in, eased value out, one item a cycle unless the output stalls.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   stream channel, in_tdata[16:0] holds the unsigned Q16 progress;
//          values above one are treated as one.
//   out_*  stream channel, out_tdata[18:0] holds the signed Q16 eased value,
//          out_tuser is set when that value was clipped to its range.
//   cfg_*  register port: control x1, y1, x2, y2 at byte addresses 0, 4, 8, 12.
//          Change the control points only while no transfer is in flight.
// Each Newton step is five multiply and setup stages, seventeen divider
// stages, one bit each, and an update stage; the NEWTON_STEPS steps are
// followed by four stages of curve evaluation and the output register.
// Throughput is one transfer per cycle while the skid register is empty.
// The pipeline moves under one enable; an output register plus a skid
// register let the last result wait while the input side keeps going, and
// in_tready falls only once the skid is full.
// Reset empties the pipeline and restores the default control points.
// ----------------------------------------------------------------------------
module cubic_bezier_easing_top #(
  parameter int NEWTON_STEPS = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,     // [16:0] progress
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,    // [18:0] eased_value
  output logic        out_tuser,    // [0] saturated
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int TW = cbe_pkg::T_W;
  localparam int YW = cbe_pkg::Y_W;
  localparam int CW = cbe_pkg::COEF_W;

  // control point registers
  logic [TW-1:0] ctrl_x1_r, ctrl_x2_r;
  logic [YW-1:0] ctrl_y1_r, ctrl_y2_r;
  logic          cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_x1_r <= cbe_pkg::X1_RST;
      ctrl_y1_r <= cbe_pkg::Y1_RST;
      ctrl_x2_r <= cbe_pkg::X2_RST;
      ctrl_y2_r <= cbe_pkg::Y2_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        cbe_pkg::REG_X1: ctrl_x1_r <= cfg_pwdata[TW-1:0];
        cbe_pkg::REG_Y1: ctrl_y1_r <= cfg_pwdata[YW-1:0];
        cbe_pkg::REG_X2: ctrl_x2_r <= cfg_pwdata[TW-1:0];
        cbe_pkg::REG_Y2: ctrl_y2_r <= cfg_pwdata[YW-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_paddr[3:2])
      cbe_pkg::REG_X1: cfg_prdata = 32'(ctrl_x1_r);
      cbe_pkg::REG_Y1: cfg_prdata = 32'(ctrl_y1_r);
      cbe_pkg::REG_X2: cfg_prdata = 32'(ctrl_x2_r);
      cbe_pkg::REG_Y2: cfg_prdata = 32'(ctrl_y2_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // polynomial coefficients of x(u), static between config writes
  logic signed [CW-1:0] x1e, x2e, x1m3, x2m3;
  cbe_pkg::coef_t       coef;

  always_comb begin
    x1e     = $signed(CW'(cbe_pkg::sat_one(ctrl_x1_r)));
    x2e     = $signed(CW'(cbe_pkg::sat_one(ctrl_x2_r)));
    x1m3    = (x1e <<< 1) + x1e;
    x2m3    = (x2e <<< 1) + x2e;
    coef.f0 = $signed(CW'(cbe_pkg::ONE_Q)) - x2m3 + x1m3;
    coef.f1 = x2m3 - (x1m3 <<< 1);
    coef.f2 = x1m3;
  end

  // pipeline enable: hold everything once the skid register is occupied
  logic en;
  logic skid_valid_r;

  assign en        = ~skid_valid_r;
  assign in_tready = en;

  // newton step chain, seeded with u = t
  wire          st_valid [NEWTON_STEPS+1];
  wire [TW-1:0] st_t     [NEWTON_STEPS+1];
  wire [TW-1:0] st_u     [NEWTON_STEPS+1];

  assign st_valid[0] = in_tvalid & in_tready;
  assign st_t[0]     = cbe_pkg::sat_one(in_tdata[TW-1:0]);
  assign st_u[0]     = cbe_pkg::sat_one(in_tdata[TW-1:0]);

  for (genvar i = 0; i < NEWTON_STEPS; i++) begin : g_step
    cbe_newton u_newton (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .coef      (coef),
      .in_valid  (st_valid[i]),
      .in_t      (st_t[i]),
      .in_u      (st_u[i]),
      .out_valid (st_valid[i+1]),
      .out_t     (st_t[i+1]),
      .out_u     (st_u[i+1])
    );
  end

  // curve evaluation
  logic          crv_valid;
  logic [YW-1:0] crv_y;
  logic          crv_sat;

  cbe_curve u_curve (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .y1        ($signed(ctrl_y1_r)),
    .y2        ($signed(ctrl_y2_r)),
    .in_valid  (st_valid[NEWTON_STEPS]),
    .in_u      (st_u[NEWTON_STEPS]),
    .out_valid (crv_valid),
    .out_y     (crv_y),
    .out_sat   (crv_sat)
  );

  // output register and skid register
  logic          out_valid_r, out_valid_nxt, skid_valid_nxt;
  logic [YW-1:0] out_y_r, skid_y_r;
  logic          out_sat_r, skid_sat_r;
  logic          push, pop, load_out, load_out_skid, load_skid;

  always_comb begin
    push           = en & crv_valid;
    pop            = out_valid_r & out_tready;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    load_out       = 1'b0;
    load_out_skid  = 1'b0;
    load_skid      = 1'b0;
    if (skid_valid_r) begin
      if (pop) begin
        load_out_skid  = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        load_out      = 1'b1;
        out_valid_nxt = 1'b1;
      end else begin
        load_skid      = 1'b1;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_y_r   <= crv_y;
      out_sat_r <= crv_sat;
    end else if (load_out_skid) begin
      out_y_r   <= skid_y_r;
      out_sat_r <= skid_sat_r;
    end
    if (load_skid) begin
      skid_y_r   <= crv_y;
      skid_sat_r <= crv_sat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(24 - YW){1'b0}}, out_y_r};
  assign out_tuser  = out_sat_r;

  // checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a result while the output register is empty");

  a_skid_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !in_tready)
    else $error("input accepted while the skid register is full");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sat_r) |->
      ($signed(out_y_r) == cbe_pkg::Y_MAX[YW-1:0] ||
       $signed(out_y_r) == cbe_pkg::Y_MIN[YW-1:0]))
    else $error("saturation flag set on a value that is not a range limit");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !skid_valid_r))
    else $error("output side not empty after reset");

endmodule
